FILE: rtl/core/bcpe_pkg.sv
`default_nettype none

package bcpe_pkg;

	// Store capacity and control point limit
	localparam int MAX_POINTS  = 16;
	localparam int STORE_DEPTH = 16;
	localparam int IDX_W       = $clog2(STORE_DEPTH);
	localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

	// Fixed point widths
	localparam int COORD_W = 24;
	localparam int T_W     = 17;
	localparam int BINOM_W = 13;
	localparam int WEIGHT_W = 29;
	localparam int ACC_W   = 58;

	// Shared multiplier operand and product widths
	localparam int MUL_A_W = 30;
	localparam int MUL_B_W = 25;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	localparam logic [T_W-1:0] ONE_Q16 = T_W'(65536);

	// Request action codes
	localparam logic [1:0] ACT_NEW    = 2'd0;
	localparam logic [1:0] ACT_APPEND = 2'd1;
	localparam logic [1:0] ACT_EVAL   = 2'd2;

	typedef struct packed {
		logic [1:0]                action;
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic [T_W-1:0]            t_param;
	} req_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] curve_x;
		logic signed [COORD_W-1:0] curve_y;
		logic [CNT_W-1:0]          points_used;
		logic                      overflowed;
	} rsp_t;

	// Pascal's triangle, rows 0 to STORE_DEPTH-1
	typedef logic [STORE_DEPTH-1:0][STORE_DEPTH-1:0][BINOM_W-1:0] binom_tab_t;

	function automatic binom_tab_t build_binom_tab();
		binom_tab_t tab;
		tab = '0;
		for (int r = 0; r < STORE_DEPTH; r++) begin
			tab[r][0] = BINOM_W'(1);
			for (int c = 1; c <= r; c++) begin
				tab[r][c] = tab[r-1][c-1] + ((c < r) ? tab[r-1][c] : BINOM_W'(0));
			end
		end
		return tab;
	endfunction

	localparam binom_tab_t BINOM_TAB = build_binom_tab();

endpackage

`default_nettype wire

FILE: rtl/core/bezier_curve_point_eval_core.sv
`default_nettype none

// Bezier point evaluator, Bernstein form, one shared 30x25 signed multiplier.
// Loads (actions 0, 1 and unused code 3) leave the sequencer idle; the next item
// can be taken in the following cycle. Evaluation steps the shared multiplier
// through every power, weight and coordinate product for each point in turn, and
// new items are stalled until it ends; it waits while the previous result is still
// held. Result is held in an output register.
// arst_n clears the sequencer, point count, overflow flag and output valid.

module bezier_curve_point_eval_core
	import bcpe_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	output rsp_t      rsp
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_PMUL = 3'd1;
	localparam logic [2:0] S_PRND = 3'd2;
	localparam logic [2:0] S_WMUL = 3'd3;
	localparam logic [2:0] S_WLAT = 3'd4;
	localparam logic [2:0] S_XMUL = 3'd5;
	localparam logic [2:0] S_YMUL = 3'd6;
	localparam logic [2:0] S_FIN  = 3'd7;

	localparam logic signed [ACC_W-17:0] SAT_MAX = (ACC_W-16)'(8388607);
	localparam logic signed [ACC_W-17:0] SAT_MIN = -(ACC_W-16)'(8388608);

	logic [2:0]                state_q;
	logic [CNT_W-1:0]          count_q;
	logic                      ovf_q;
	logic [IDX_W-1:0]          n_q;
	logic [IDX_W-1:0]          i_q;
	logic [IDX_W-1:0]          j_q;
	logic [T_W-1:0]            t_q;
	logic [T_W-1:0]            u_q;
	logic [T_W-1:0]            p_q;
	logic [WEIGHT_W-1:0]       w_q;
	logic signed [ACC_W-1:0]   acc_x_q;
	logic signed [ACC_W-1:0]   acc_y_q;
	logic [2*COORD_W-1:0]      store_mem [STORE_DEPTH];
	logic [2*COORD_W-1:0]      rd_q;
	logic                      rsp_valid_q;
	rsp_t                      rsp_q;
	logic                      last_y_q;

	logic                      req_xfer;
	logic                      rsp_xfer;
	logic                      store_wr;
	logic [IDX_W-1:0]          store_addr;
	logic [T_W-1:0]            t_sat;
	logic [T_W-1:0]            pow_f;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  prod;
	logic [T_W+16:0]           p_round;
	logic signed [ACC_W-1:0]   prod_ext;
	logic signed [ACC_W-1:0]   rnd_x;
	logic signed [ACC_W-17:0]  q_x;
	logic [COORD_W-1:0]        sat_x;
	logic                      fin_go;
	logic signed [ACC_W-1:0]   acc_y_fin;
	logic [COORD_W-1:0]        sat_yf;
	logic signed [ACC_W-1:0]   rnd_yf;
	logic signed [ACC_W-17:0]  q_yf;

	assign req_stall = (state_q != S_IDLE);
	assign req_xfer  = req_valid && !req_stall;
	assign rsp_xfer  = rsp_valid_q && !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign fin_go    = !rsp_valid_q || !rsp_stall;

	// Clamp t to one and pick the power factor: u for the first n-i steps
	assign t_sat = (req.t_param > ONE_Q16) ? ONE_Q16 : req.t_param;
	assign pow_f = (j_q < (n_q - i_q)) ? u_q : t_q;

	// Point store write on load
	always_comb begin
		store_wr   = 1'b0;
		store_addr = count_q[IDX_W-1:0];
		if (req_xfer) begin
			if (req.action == ACT_NEW) begin
				store_wr   = 1'b1;
				store_addr = '0;
			end else if (req.action == ACT_APPEND && count_q < CNT_W'(MAX_POINTS)) begin
				store_wr = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (store_wr) begin
			store_mem[store_addr] <= {req.point_x, req.point_y};
		end
		rd_q <= store_mem[i_q];
	end

	// Operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_PMUL: begin
				mul_a = MUL_A_W'(p_q);
				mul_b = MUL_B_W'(pow_f);
			end
			S_WMUL: begin
				mul_a = MUL_A_W'(p_q);
				mul_b = MUL_B_W'(BINOM_TAB[n_q][i_q]);
			end
			S_XMUL: begin
				mul_a = MUL_A_W'(w_q);
				mul_b = MUL_B_W'($signed(rd_q[2*COORD_W-1:COORD_W]));
			end
			S_YMUL: begin
				mul_a = MUL_A_W'(w_q);
				mul_b = MUL_B_W'($signed(rd_q[COORD_W-1:0]));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	bcpe_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	// Round half up after each power step; product stays within 33 bits
	assign p_round  = (T_W+17)'(prod[T_W+16:0]) + (T_W+17)'(32768);
	assign prod_ext = ACC_W'(prod);

	// Final rounding: floor(s / 65536 + 0.5), then saturate
	assign rnd_x = acc_x_q + ACC_W'(32768);
	assign q_x   = rnd_x[ACC_W-1:16];

	always_comb begin
		if (q_x > SAT_MAX) begin
			sat_x = SAT_MAX[COORD_W-1:0];
		end else if (q_x < SAT_MIN) begin
			sat_x = SAT_MIN[COORD_W-1:0];
		end else begin
			sat_x = q_x[COORD_W-1:0];
		end
	end

	// Sequencer, point count and overflow flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_xfer) begin
						unique case (req.action)
							ACT_NEW: begin
								count_q <= CNT_W'(1);
								ovf_q   <= 1'b0;
							end
							ACT_APPEND: begin
								if (count_q < CNT_W'(MAX_POINTS)) begin
									count_q <= count_q + CNT_W'(1);
								end else begin
									ovf_q <= 1'b1;
								end
							end
							ACT_EVAL: begin
								if (count_q == '0) begin
									state_q <= S_FIN;
								end else if (count_q == CNT_W'(1)) begin
									state_q <= S_WMUL;
								end else begin
									state_q <= S_PMUL;
								end
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_PMUL: state_q <= S_PRND;
				S_PRND: state_q <= (j_q == n_q - IDX_W'(1)) ? S_WMUL : S_PMUL;
				S_WMUL: state_q <= S_WLAT;
				S_WLAT: state_q <= S_XMUL;
				S_XMUL: state_q <= S_YMUL;
				S_YMUL: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (i_q != n_q) begin
						state_q <= S_PMUL;
					end else if (fin_go) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (req_xfer && req.action == ACT_EVAL) begin
					t_q     <= t_sat;
					u_q     <= ONE_Q16 - t_sat;
					// Empty set: n stays zero so FIN ends without stepping through any point
					n_q     <= (count_q == '0) ? '0 : count_q[IDX_W-1:0] - IDX_W'(1);
					i_q     <= '0;
					j_q     <= '0;
					p_q     <= ONE_Q16;
					acc_x_q <= '0;
					acc_y_q <= '0;
				end
			end
			S_PRND: begin
				p_q <= p_round[T_W+15:16];
				j_q <= (j_q == n_q - IDX_W'(1)) ? '0 : j_q + IDX_W'(1);
			end
			S_WLAT: begin
				w_q <= prod[WEIGHT_W-1:0];
			end
			S_YMUL: begin
				acc_x_q <= acc_x_q + prod_ext;
			end
			S_FIN: begin
				// FIN after any point but the last takes the y product and steps to the next
				if (i_q != n_q) begin
					acc_y_q <= acc_y_q + prod_ext;
					i_q     <= i_q + IDX_W'(1);
					p_q     <= ONE_Q16;
					j_q     <= '0;
				end else if (last_y_q && !fin_go) begin
					// Hold the completed y sum while the output register is busy
					acc_y_q <= acc_y_fin;
				end
			end
			default: begin
			end
		endcase
	end

	// y accumulate for the last point, tracked separately from the FIN wait
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_y_q <= 1'b0;
		end else begin
			last_y_q <= (state_q == S_YMUL) && (i_q == n_q);
		end
	end

	// On the first cycle of the last FIN the y product is folded in directly
	assign acc_y_fin = last_y_q ? (acc_y_q + prod_ext) : acc_y_q;
	assign rnd_yf    = acc_y_fin + ACC_W'(32768);
	assign q_yf      = rnd_yf[ACC_W-1:16];

	always_comb begin
		if (q_yf > SAT_MAX) begin
			sat_yf = SAT_MAX[COORD_W-1:0];
		end else if (q_yf < SAT_MIN) begin
			sat_yf = SAT_MIN[COORD_W-1:0];
		end else begin
			sat_yf = q_yf[COORD_W-1:0];
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == S_FIN && i_q == n_q && fin_go) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_xfer) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FIN && i_q == n_q && fin_go) begin
			rsp_q.curve_x     <= $signed(sat_x);
			rsp_q.curve_y     <= (count_q == '0) ? '0 : $signed(sat_yf);
			rsp_q.points_used <= count_q;
			rsp_q.overflowed  <= ovf_q;
		end
	end

	// Checks on the sequencer and store bookkeeping
	property p_count_bound;
		@(posedge clk) disable iff (!arst_n) count_q <= CNT_W'(MAX_POINTS);
	endproperty
	a_count_bound: assert property (p_count_bound)
		else $error("point count above capacity");

	property p_power_step_bound;
		@(posedge clk) disable iff (!arst_n) (state_q == S_PRND) |-> (j_q < n_q);
	endproperty
	a_power_step_bound: assert property (p_power_step_bound)
		else $error("power step counter past n");

	property p_power_bound;
		@(posedge clk) disable iff (!arst_n)
			(state_q == S_PMUL || state_q == S_WMUL) |-> (p_q <= ONE_Q16);
	endproperty
	a_power_bound: assert property (p_power_bound)
		else $error("power product above one");

	property p_result_count;
		@(posedge clk) disable iff (!arst_n)
			$rose(rsp_valid_q) |-> (rsp_q.points_used == count_q && rsp_q.overflowed == ovf_q);
	endproperty
	a_result_count: assert property (p_result_count)
		else $error("result count or flag differs from store state");

endmodule

`default_nettype wire

FILE: rtl/core/bcpe_mul.sv
`default_nettype none

module bcpe_mul
	import bcpe_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic signed [MUL_A_W-1:0] a,
	input  wire logic signed [MUL_B_W-1:0] b,
	output logic signed [PROD_W-1:0]       prod
);

	// Signed multiply, product registered
	always_ff @(posedge clk) begin
		prod <= a * b;
	end

endmodule

`default_nettype wire
